>>> hdl/lightmap_skyline_allocator_core_assert.svh
// =============================================================================
// Assertion macros for the skyline allocator
// Shared same-cycle-implication and next-cycle-implication checks, clocked on
// clk and disabled while rst_n is low.
// =============================================================================
`ifndef LIGHTMAP_SKYLINE_ALLOCATOR_CORE_ASSERT_SVH
`define LIGHTMAP_SKYLINE_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define LSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lsa_pkg.sv
// =============================================================================
// lsa_pkg
// Types and fixed constants of the skyline lightmap allocator.
// =============================================================================
package lsa_pkg;

  localparam int unsigned EXT_W     = 12;  // extent field width
  localparam int unsigned EXT_SHIFT = 4;   // texels per cell, log2
  localparam int unsigned SIZE_W    = 9;   // region size in cells, 1..256
  localparam int unsigned PAGE_W    = 16;
  localparam int unsigned POS_W     = 7;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREFIX,
    ST_SUFFIX,
    ST_DRAIN,
    ST_DECIDE,
    ST_FILL,
    ST_SWEEP,
    ST_DONE
  } lsa_state_t;

  // scan control, aligned with the height read data
  typedef struct packed {
    logic pre;    // prefix pass beat
    logic suf;    // suffix pass beat
    logic first;  // first beat of the pass
  } lsa_scan_ctl_t;

endpackage

>>> hdl/lsa_wmax.sv
// =============================================================================
// lsa_wmax
// Sliding window maximum over the skyline by block prefix and suffix maxima.
// =============================================================================
module lsa_wmax
  import lsa_pkg::*;
#(
  parameter int COLUMNS = 128,
  parameter int ROWS    = 128,
  localparam int CW     = $clog2(COLUMNS),
  localparam int HW     = $clog2(ROWS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lsa_scan_ctl_t         ctl_i,
  input  logic [CW-1:0]         idx_i,
  input  logic [HW-1:0]         hgt_i,
  input  logic [SIZE_W-1:0]     size_i,
  input  logic [CW-1:0]         paddr_i,
  output logic                  cand_vld_o,
  output logic [HW-1:0]         cand_max_o,
  output logic [CW-1:0]         cand_idx_o
);

  localparam int CMPW = ((CW + 1 > SIZE_W) ? CW + 1 : SIZE_W) + 1;

  logic [HW-1:0]     pre_mem [COLUMNS];
  logic [HW-1:0]     pre_rdata_r;

  logic [SIZE_W-1:0] pos_r, pos_eff, pos_nxt;
  logic [SIZE_W-1:0] spos_r, spos_eff, spos_nxt;
  logic [SIZE_W-1:0] lastpos_r;
  logic [SIZE_W-1:0] size_m1;
  logic [HW-1:0]     pre_max_r, pre_max;
  logic [HW-1:0]     suf_max_r, suf_max;
  logic [HW-1:0]     win_max;
  logic              in_range;

  logic              cand_vld_r;
  logic [HW-1:0]     cand_max_r;
  logic [CW-1:0]     cand_idx_r;

  always_comb begin
    size_m1  = size_i - SIZE_W'(1);
    // prefix: running max from the block start, left to right
    pos_eff  = ctl_i.first ? '0 : pos_r;
    pre_max  = (pos_eff == '0 || hgt_i > pre_max_r) ? hgt_i : pre_max_r;
    pos_nxt  = (pos_eff == size_m1) ? '0 : pos_eff + SIZE_W'(1);
    // suffix: running max to the block end, right to left
    spos_eff = ctl_i.first ? lastpos_r : spos_r;
    suf_max  = (ctl_i.first || spos_eff == size_m1 || hgt_i > suf_max_r) ? hgt_i : suf_max_r;
    spos_nxt = (spos_eff == '0) ? size_m1 : spos_eff - SIZE_W'(1);
    win_max  = (pre_rdata_r > suf_max) ? pre_rdata_r : suf_max;
    in_range = (CMPW'(idx_i) + CMPW'(size_i)) < CMPW'(COLUMNS);
  end

  always_ff @(posedge clk) begin
    if (ctl_i.pre) begin
      pre_mem[idx_i] <= pre_max;
      pos_r          <= pos_nxt;
      pre_max_r      <= pre_max;
      if (idx_i == CW'(COLUMNS - 1)) begin
        lastpos_r <= pos_eff;
      end
    end
    if (ctl_i.suf) begin
      spos_r    <= spos_nxt;
      suf_max_r <= suf_max;
    end
    pre_rdata_r <= pre_mem[paddr_i];
    cand_max_r  <= win_max;
    cand_idx_r  <= idx_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_vld_r <= 1'b0;
    end else begin
      cand_vld_r <= ctl_i.suf && in_range;
    end
  end

  assign cand_vld_o = cand_vld_r;
  assign cand_max_o = cand_max_r;
  assign cand_idx_o = cand_idx_r;

endmodule

>>> hdl/lightmap_skyline_allocator_core.sv
// =============================================================================
// lightmap_skyline_allocator_core
// Skyline packer for lightmap atlas pages: places w x h cell regions at the
// leftmost lowest window of the per-column height profile.
// =============================================================================
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-----------------------------------------
//  in_     | in  | tvalid / tready   | tdata: extent_s, extent_t; tuser: unlit
//  out_    | out | tvalid / tready   | tdata: page, pos_s, pos_t;
//          |     |                   | tuser: placed, page_closed
//
//  Steps: a request runs a prefix pass and a suffix pass over the height
//  memory, then a window write of w columns; closing a page replaces the
//  window write by a sweep over all columns, and a request too big for a
//  page goes to that sweep at once. Unlit requests skip to the result.
//  Reset: a clearing pass over all columns of the height memory follows
//  reset; in_tready stays low during it.
//  Stalls: one result is held in the output register while the next request
//  is taken and worked; the block waits before loading a second result.
//
`include "lightmap_skyline_allocator_core_assert.svh"

module lightmap_skyline_allocator_core
  import lsa_pkg::*;
#(
  parameter int COLUMNS = 128,
  parameter int ROWS    = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [11:0] extent_s, [23:12] extent_t
  input  logic        in_tuser,   // [0] unlit
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] page, [22:16] pos_s, [29:23] pos_t
  output logic [1:0]  out_tuser   // [0] placed, [1] page_closed
);

  localparam int CW   = $clog2(COLUMNS);
  localparam int HW   = $clog2(ROWS + 1);
  localparam int CMPW = ((CW + 1 > SIZE_W) ? CW + 1 : SIZE_W) + 1;
  localparam int SUMW = ((HW > SIZE_W) ? HW : SIZE_W) + 1;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  lsa_state_t        state_r, state_nxt;
  logic [CW-1:0]     addr_r, addr_nxt;
  logic [SIZE_W-1:0] size_s_r, size_s_nxt;
  logic [SIZE_W-1:0] size_t_r, size_t_nxt;
  logic [SIZE_W-1:0] cnt_r, cnt_nxt;
  logic [HW-1:0]     best_r, best_nxt;
  logic [CW-1:0]     bx_r, bx_nxt;
  logic [HW-1:0]     fill_val_r, fill_val_nxt;
  logic              retry_r, retry_nxt;
  logic              drain_r, drain_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic              pend_placed_r, pend_placed_nxt;
  logic              pend_closed_r, pend_closed_nxt;
  logic [POS_W-1:0]  pend_pos_s_r, pend_pos_s_nxt;
  logic [POS_W-1:0]  pend_pos_t_r, pend_pos_t_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_placed_r, out_placed_nxt;
  logic              out_closed_r, out_closed_nxt;
  logic [PAGE_W-1:0] out_page_r, out_page_nxt;
  logic [POS_W-1:0]  out_pos_s_r, out_pos_s_nxt;
  logic [POS_W-1:0]  out_pos_t_r, out_pos_t_nxt;
  lsa_scan_ctl_t     rd_ctl_r, rd_ctl;
  logic [CW-1:0]     rd_idx_r;

  // height memory
  logic [HW-1:0]     hgt_mem [COLUMNS];
  logic [HW-1:0]     hgt_rdata_r;
  logic              mem_we;
  logic [CW-1:0]     mem_waddr;
  logic [HW-1:0]     mem_wdata;
  logic [CW-1:0]     mem_raddr;
  logic [CW-1:0]     paddr;

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  logic              in_fire, out_fire, load_out;
  logic [SIZE_W-1:0] size_s_in, size_t_in;
  logic              too_big, fits, last_col;
  logic [SUMW-1:0]   top_sum;

  logic              cand_vld;
  logic [HW-1:0]     cand_max;
  logic [CW-1:0]     cand_idx;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign last_col  = (addr_r == CW'(COLUMNS - 1));

  // region size in cells: (extent >> 4) + 1
  assign size_s_in = {1'b0, in_tdata[EXT_W-1:EXT_SHIFT]} + SIZE_W'(1);
  assign size_t_in = {1'b0, in_tdata[2*EXT_W-1:EXT_W+EXT_SHIFT]} + SIZE_W'(1);

  // no start column, or taller than a page: both tries fail
  assign too_big = (CMPW'(size_s_in) >= CMPW'(COLUMNS)) || (SUMW'(size_t_in) > SUMW'(ROWS));

  assign top_sum = SUMW'(best_r) + SUMW'(size_t_r);
  assign fits    = (top_sum <= SUMW'(ROWS));

  // P read for the window tail column, issued with the height read
  assign paddr   = CW'(CMPW'(addr_r) + CMPW'(size_s_r) - CMPW'(1));

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (last_col) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser)     state_nxt = ST_DONE;
          else if (too_big) state_nxt = ST_SWEEP;
          else              state_nxt = ST_PREFIX;
        end
      end
      ST_PREFIX: begin
        if (last_col) state_nxt = ST_SUFFIX;
      end
      ST_SUFFIX: begin
        if (addr_r == '0) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_r) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = fits ? ST_FILL : ST_SWEEP;
      end
      ST_FILL: begin
        if (cnt_r == '0) state_nxt = ST_DONE;
      end
      ST_SWEEP: begin
        if (last_col) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and memory control
  // ---------------------------------------------------------------------------
  always_comb begin
    addr_nxt        = addr_r;
    size_s_nxt      = size_s_r;
    size_t_nxt      = size_t_r;
    cnt_nxt         = cnt_r;
    best_nxt        = best_r;
    bx_nxt          = bx_r;
    fill_val_nxt    = fill_val_r;
    retry_nxt       = retry_r;
    drain_nxt       = drain_r;
    page_nxt        = page_r;
    pend_placed_nxt = pend_placed_r;
    pend_closed_nxt = pend_closed_r;
    pend_pos_s_nxt  = pend_pos_s_r;
    pend_pos_t_nxt  = pend_pos_t_r;
    out_placed_nxt  = out_placed_r;
    out_closed_nxt  = out_closed_r;
    out_page_nxt    = out_page_r;
    out_pos_s_nxt   = out_pos_s_r;
    out_pos_t_nxt   = out_pos_t_r;
    out_valid_nxt   = out_fire ? 1'b0 : out_valid_r;
    rd_ctl          = '0;
    mem_we          = 1'b0;
    mem_waddr       = addr_r;
    mem_wdata       = '0;
    mem_raddr       = addr_r;

    // track the leftmost least window; scan runs right to left, so ties win
    if (cand_vld && cand_max <= best_r) begin
      best_nxt = cand_max;
      bx_nxt   = cand_idx;
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        addr_nxt = last_col ? '0 : addr_r + CW'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          size_s_nxt      = size_s_in;
          size_t_nxt      = size_t_in;
          best_nxt        = HW'(ROWS);
          addr_nxt        = '0;
          retry_nxt       = 1'b0;
          pend_placed_nxt = 1'b0;
          pend_closed_nxt = 1'b0;
          pend_pos_s_nxt  = '0;
          pend_pos_t_nxt  = '0;
          if (!in_tuser && too_big) begin
            // close the page; the retry cannot succeed either
            page_nxt        = page_r + PAGE_W'(1);
            pend_closed_nxt = 1'b1;
          end
        end
      end
      ST_PREFIX: begin
        rd_ctl.pre   = 1'b1;
        rd_ctl.first = (addr_r == '0);
        addr_nxt     = last_col ? CW'(COLUMNS - 1) : addr_r + CW'(1);
      end
      ST_SUFFIX: begin
        rd_ctl.suf   = 1'b1;
        rd_ctl.first = last_col;
        addr_nxt     = addr_r - CW'(1);
        drain_nxt    = 1'b0;
      end
      ST_DRAIN: begin
        drain_nxt = 1'b1;
      end
      ST_DECIDE: begin
        pend_placed_nxt = 1'b1;
        if (fits) begin
          pend_pos_s_nxt = POS_W'(bx_r);
          pend_pos_t_nxt = POS_W'(best_r);
          fill_val_nxt   = HW'(top_sum);
          addr_nxt       = bx_r;
          cnt_nxt        = size_s_r - SIZE_W'(1);
        end else begin
          // close the page; on the fresh page the region lands at the origin
          page_nxt        = page_r + PAGE_W'(1);
          pend_closed_nxt = 1'b1;
          pend_pos_s_nxt  = '0;
          pend_pos_t_nxt  = '0;
          fill_val_nxt    = HW'(size_t_r);
          retry_nxt       = 1'b1;
          addr_nxt        = '0;
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = fill_val_r;
        addr_nxt  = addr_r + CW'(1);
        cnt_nxt   = cnt_r - SIZE_W'(1);
      end
      ST_SWEEP: begin
        // clear the page, raising the first w columns when the retry places
        mem_we = 1'b1;
        if (retry_r && (CMPW'(addr_r) < CMPW'(size_s_r))) begin
          mem_wdata = fill_val_r;
        end
        addr_nxt = last_col ? '0 : addr_r + CW'(1);
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_nxt  = 1'b1;
          out_placed_nxt = pend_placed_r;
          out_closed_nxt = pend_closed_r;
          out_page_nxt   = pend_placed_r ? page_r : '0;
          out_pos_s_nxt  = pend_pos_s_r;
          out_pos_t_nxt  = pend_pos_t_r;
        end
      end
      default: begin
        addr_nxt = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      page_r      <= PAGE_W'(1);
      out_valid_r <= 1'b0;
      rd_ctl_r    <= '0;
      drain_r     <= 1'b0;
      retry_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      page_r      <= page_nxt;
      out_valid_r <= out_valid_nxt;
      rd_ctl_r    <= rd_ctl;
      drain_r     <= drain_nxt;
      retry_r     <= retry_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    size_s_r      <= size_s_nxt;
    size_t_r      <= size_t_nxt;
    cnt_r         <= cnt_nxt;
    best_r        <= best_nxt;
    bx_r          <= bx_nxt;
    fill_val_r    <= fill_val_nxt;
    pend_placed_r <= pend_placed_nxt;
    pend_closed_r <= pend_closed_nxt;
    pend_pos_s_r  <= pend_pos_s_nxt;
    pend_pos_t_r  <= pend_pos_t_nxt;
    out_placed_r  <= out_placed_nxt;
    out_closed_r  <= out_closed_nxt;
    out_page_r    <= out_page_nxt;
    out_pos_s_r   <= out_pos_s_nxt;
    out_pos_t_r   <= out_pos_t_nxt;
    rd_idx_r      <= addr_r;
  end

  // ---------------------------------------------------------------------------
  // Height memory: one write, one registered read
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hgt_mem[mem_waddr] <= mem_wdata;
    end
    hgt_rdata_r <= hgt_mem[mem_raddr];
  end

  // ---------------------------------------------------------------------------
  // Window maximum unit
  // ---------------------------------------------------------------------------
  lsa_wmax #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_wmax (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (rd_ctl_r),
    .idx_i      (rd_idx_r),
    .hgt_i      (hgt_rdata_r),
    .size_i     (size_s_r),
    .paddr_i    (paddr),
    .cand_vld_o (cand_vld),
    .cand_max_o (cand_max),
    .cand_idx_o (cand_idx)
  );

  // ---------------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------------
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_pos_t_r, out_pos_s_r, out_page_r};
  assign out_tuser  = {out_closed_r, out_placed_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `LSA_ASSERT_IMP(a_write_states, mem_we, state_r == ST_CLEAR || state_r == ST_FILL || state_r == ST_SWEEP, "height write outside a write state")
  `LSA_ASSERT_IMP(a_cand_window, cand_vld, state_r == ST_SUFFIX || state_r == ST_DRAIN, "window candidate outside the suffix pass")
  `LSA_ASSERT_NXT(a_accept_busy, in_fire, state_r != ST_IDLE, "request accepted without starting work")
  `LSA_ASSERT_IMP(a_best_bound, state_r == ST_DECIDE, best_r <= HW'(ROWS), "best window height above page height")

endmodule
